@@ rtl/bgpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bgpc_pkg
// Shared types and constants for the biped gait phase classifier.
// ----------------------------------------------------------------------------
package bgpc_pkg;

    // default timestamp width
    localparam int TIME_BITS_DEF = 48;

    // configuration register layout
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 24;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STRIKE_BLACKOUT = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BREAK_BLACKOUT  = 8'd1;
    localparam logic [CFG_DATA_BITS-1:0] STRIKE_BLACKOUT_RST = 24'd95000;
    localparam logic [CFG_DATA_BITS-1:0] BREAK_BLACKOUT_RST  = 24'd800000;

    // gait phases
    localparam int PHASE_BITS = 4;
    typedef logic [PHASE_BITS-1:0] phase_t;
    localparam phase_t PH_L_STAND  = 4'd0;
    localparam phase_t PH_L_BREAK  = 4'd1;
    localparam phase_t PH_L_SWING  = 4'd2;
    localparam phase_t PH_L_STRIKE = 4'd3;
    localparam phase_t PH_R_STAND  = 4'd4;
    localparam phase_t PH_R_BREAK  = 4'd5;
    localparam phase_t PH_R_SWING  = 4'd6;
    localparam phase_t PH_R_STRIKE = 4'd7;
    localparam phase_t PH_UNKNOWN  = 4'd8;

    // odometry status codes
    typedef logic [1:0] odo_status_t;
    localparam odo_status_t ODO_ACCURATE   = 2'd0;
    localparam odo_status_t ODO_INACCURATE = 2'd1;
    localparam odo_status_t ODO_UNUSABLE   = 2'd2;

    // contact flags of one sample
    typedef struct packed {
        logic left_weak;
        logic right_weak;
        logic left_strong;
        logic right_strong;
    } contact_t;

    // outcome of one phase update
    typedef struct packed {
        phase_t phase;
        logic   started;
        logic   rec_break;
        logic   rec_strike;
        logic   switched;
        logic   bad;
    } decision_t;

endpackage

@@ rtl/biped_gait_phase_classifier.sv @@
// ----------------------------------------------------------------------------
// biped_gait_phase_classifier
// Gait phase and odometry status from timestamped foot contact samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one beat per contact sample (timestamp plus four flags).
//   m_* channel: one beat per sample with phase, odometry status and flags.
//   cfg_* channel: writes the strike (index 0) and break (index 1) blackout
//   spans; always ready, write only while no sample is in flight.
// Flow: a sample accepted into the input register moves on into the result
//   register and is presented on m_*; one sample per cycle while m_ready is high.
// The sample sits in an input register; at the edge it moves into the
//   result register the gait state updates and both windows are checked
//   against the updated break and strike times.
// Reset: phase unknown, not started, stored times zero, spans to defaults.
// Stall: while m_ready is low the result holds; one more sample is taken
//   into the input register, then s_ready drops until the result leaves.
// ----------------------------------------------------------------------------
module biped_gait_phase_classifier #(
    parameter int TIME_BITS = bgpc_pkg::TIME_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // sample input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [TIME_BITS-1:0]               s_time_us,
    input  logic                               s_left_weak,
    input  logic                               s_right_weak,
    input  logic                               s_left_strong,
    input  logic                               s_right_strong,
    // result output
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [3:0]                         m_gait_phase,
    output logic [1:0]                         m_odo_status,
    output logic                               m_primary_switched,
    output logic                               m_bad_transition,
    output logic                               m_started,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bgpc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [bgpc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    // configuration registers
    logic [bgpc_pkg::CFG_DATA_BITS-1:0] strike_span_reg;
    logic [bgpc_pkg::CFG_DATA_BITS-1:0] break_span_reg;

    // input register
    logic                     in_valid_reg;
    logic [TIME_BITS-1:0]     in_time_reg;
    bgpc_pkg::contact_t       in_contact_reg;

    // gait state
    bgpc_pkg::phase_t         phase_reg;
    logic                     started_reg;
    logic [TIME_BITS-1:0]     strike_time_reg;
    logic [TIME_BITS-1:0]     break_time_reg;
    logic [TIME_BITS-1:0]     strike_time_next;
    logic [TIME_BITS-1:0]     break_time_next;

    // result register
    logic                     out_valid_reg;
    bgpc_pkg::phase_t         out_phase_reg;
    bgpc_pkg::odo_status_t    out_status_reg;
    logic                     out_switched_reg;
    logic                     out_bad_reg;
    logic                     out_started_reg;
    bgpc_pkg::odo_status_t    status_next;

    logic                     advance;
    bgpc_pkg::decision_t      decision;
    logic                     strike_active;
    logic                     break_active;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    // configuration write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strike_span_reg <= bgpc_pkg::STRIKE_BLACKOUT_RST;
            break_span_reg  <= bgpc_pkg::BREAK_BLACKOUT_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == bgpc_pkg::CFG_STRIKE_BLACKOUT) begin
                strike_span_reg <= cfg_data;
            end else if (cfg_index == bgpc_pkg::CFG_BREAK_BLACKOUT) begin
                break_span_reg <= cfg_data;
            end
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_time_reg                 <= s_time_us;
            in_contact_reg.left_weak    <= s_left_weak;
            in_contact_reg.right_weak   <= s_right_weak;
            in_contact_reg.left_strong  <= s_left_strong;
            in_contact_reg.right_strong <= s_right_strong;
        end
    end

    // phase update
    bgpc_phase_next u_phase_next (
        .phase    (phase_reg),
        .started  (started_reg),
        .contact  (in_contact_reg),
        .decision (decision)
    );

    // timestamps recorded on break and strike entry
    assign break_time_next  = decision.rec_break  ? in_time_reg : break_time_reg;
    assign strike_time_next = decision.rec_strike ? in_time_reg : strike_time_reg;

    // blackout windows against the updated times
    bgpc_window #(.TIME_BITS(TIME_BITS)) u_strike_window (
        .now    (in_time_reg),
        .since  (strike_time_next),
        .span   (strike_span_reg),
        .active (strike_active)
    );

    bgpc_window #(.TIME_BITS(TIME_BITS)) u_break_window (
        .now    (in_time_reg),
        .since  (break_time_next),
        .span   (break_span_reg),
        .active (break_active)
    );

    // strike window wins over break window
    always_comb begin
        if (strike_active) begin
            status_next = bgpc_pkg::ODO_UNUSABLE;
        end else if (break_active) begin
            status_next = bgpc_pkg::ODO_INACCURATE;
        end else begin
            status_next = bgpc_pkg::ODO_ACCURATE;
        end
    end

    // gait state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= bgpc_pkg::PH_UNKNOWN;
            started_reg     <= 1'b0;
            strike_time_reg <= '0;
            break_time_reg  <= '0;
        end else if (advance) begin
            phase_reg       <= decision.phase;
            started_reg     <= decision.started;
            strike_time_reg <= strike_time_next;
            break_time_reg  <= break_time_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_phase_reg    <= decision.phase;
            out_status_reg   <= status_next;
            out_switched_reg <= decision.switched;
            out_bad_reg      <= decision.bad;
            out_started_reg  <= decision.started;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_gait_phase       = out_phase_reg;
    assign m_odo_status       = out_status_reg;
    assign m_primary_switched = out_switched_reg;
    assign m_bad_transition   = out_bad_reg;
    assign m_started          = out_started_reg;

`ifndef SYNTHESIS
    // once started the machine never returns to the waiting state
    a_started_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg |=> started_reg)
        else $error("started flag dropped");

    // before start the phase stays unknown
    a_unknown_until_start: assert property (@(posedge aclk) disable iff (!aresetn)
        !started_reg |-> (phase_reg == bgpc_pkg::PH_UNKNOWN))
        else $error("phase left unknown before start");

    // a primary switch always lands in a break phase and is never a bad beat
    a_switch_into_break: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_switched_reg) |->
            (!out_bad_reg && ((out_phase_reg == bgpc_pkg::PH_L_BREAK) ||
                              (out_phase_reg == bgpc_pkg::PH_R_BREAK))))
        else $error("primary switch outside a break phase");

    // input side only stalls when both registers are full and output blocked
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without backpressure");
`endif

endmodule

@@ rtl/bgpc_phase_next.sv @@
// ----------------------------------------------------------------------------
// bgpc_phase_next
// Next-phase logic of the eight-phase gait machine for one contact sample.
// ----------------------------------------------------------------------------
module bgpc_phase_next (
    input  bgpc_pkg::phase_t    phase,
    input  logic                started,
    input  bgpc_pkg::contact_t  contact,
    output bgpc_pkg::decision_t decision
);

    logic lw, rw, ls, rs;

    assign lw = contact.left_weak;
    assign rw = contact.right_weak;
    assign ls = contact.left_strong;
    assign rs = contact.right_strong;

    // transition table
    always_comb begin
        decision            = '0;
        decision.phase      = phase;
        decision.started    = started;
        if (!started) begin
            // wait for both feet down
            if (lw && rw) begin
                decision.phase   = bgpc_pkg::PH_L_STAND;
                decision.started = 1'b1;
            end
        end else begin
            case (phase)
                bgpc_pkg::PH_L_STAND: begin
                    if (lw && !rs) begin
                        decision.phase     = bgpc_pkg::PH_L_BREAK;
                        decision.rec_break = 1'b1;
                    end else if (!ls && rw) begin
                        decision.phase     = bgpc_pkg::PH_R_BREAK;
                        decision.rec_break = 1'b1;
                        decision.switched  = 1'b1;
                    end else if (!(lw && rw)) begin
                        decision.bad = 1'b1;
                    end
                end
                bgpc_pkg::PH_L_BREAK: begin
                    if (lw && !rw)      decision.phase = bgpc_pkg::PH_L_SWING;
                    else if (lw && rs)  decision.phase = bgpc_pkg::PH_L_STAND;
                    else if (!lw)       decision.bad   = 1'b1;
                end
                bgpc_pkg::PH_L_SWING: begin
                    if (lw && rw) begin
                        decision.phase      = bgpc_pkg::PH_L_STRIKE;
                        decision.rec_strike = 1'b1;
                    end else if (!lw && rw) begin
                        decision.bad = 1'b1;
                    end
                end
                bgpc_pkg::PH_L_STRIKE: begin
                    if (lw && rs)  decision.phase = bgpc_pkg::PH_L_STAND;
                    else if (!lw)  decision.bad   = 1'b1;
                end
                bgpc_pkg::PH_R_STAND: begin
                    if (!ls && rw) begin
                        decision.phase     = bgpc_pkg::PH_R_BREAK;
                        decision.rec_break = 1'b1;
                    end else if (lw && !rs) begin
                        decision.phase     = bgpc_pkg::PH_L_BREAK;
                        decision.rec_break = 1'b1;
                        decision.switched  = 1'b1;
                    end else if (!(lw && rw)) begin
                        decision.bad = 1'b1;
                    end
                end
                bgpc_pkg::PH_R_BREAK: begin
                    if (!lw && rw)      decision.phase = bgpc_pkg::PH_R_SWING;
                    else if (ls && rw)  decision.phase = bgpc_pkg::PH_R_STAND;
                    else if (!rw)       decision.bad   = 1'b1;
                end
                bgpc_pkg::PH_R_SWING: begin
                    if (lw && rw) begin
                        decision.phase      = bgpc_pkg::PH_R_STRIKE;
                        decision.rec_strike = 1'b1;
                    end else if (lw && !rw) begin
                        decision.bad = 1'b1;
                    end
                end
                bgpc_pkg::PH_R_STRIKE: begin
                    if (ls && rw)  decision.phase = bgpc_pkg::PH_R_STAND;
                    else if (!rw)  decision.bad   = 1'b1;
                end
                default: begin
                    decision.bad = 1'b1;
                end
            endcase
        end
    end

endmodule

@@ rtl/bgpc_window.sv @@
// ----------------------------------------------------------------------------
// bgpc_window
// Blackout window check: true while now lies before since plus span, or
// when now is earlier than since.
// ----------------------------------------------------------------------------
module bgpc_window #(
    parameter int TIME_BITS = bgpc_pkg::TIME_BITS_DEF
) (
    input  logic [TIME_BITS-1:0]               now,
    input  logic [TIME_BITS-1:0]               since,
    input  logic [bgpc_pkg::CFG_DATA_BITS-1:0] span,
    output logic                               active
);

    logic [TIME_BITS:0] diff;

    // borrow bit flags time going backwards
    assign diff   = {1'b0, now} - {1'b0, since};
    assign active = diff[TIME_BITS] ||
                    (diff[TIME_BITS-1:0] <
                     {{(TIME_BITS-bgpc_pkg::CFG_DATA_BITS){1'b0}}, span});

endmodule

@@ tb/bgpc_checker.sv @@
// ----------------------------------------------------------------------------
// bgpc_checker
// Watches the sample, result and configuration channels of the gait phase
// classifier. It keeps its own copy of the gait state and the blackout spans,
// predicts one result per accepted sample, and compares each result beat
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bgpc_checker #(
    parameter int TIME_BITS = bgpc_pkg::TIME_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [TIME_BITS-1:0]               s_time_us,
    input  logic                               s_left_weak,
    input  logic                               s_right_weak,
    input  logic                               s_left_strong,
    input  logic                               s_right_strong,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [3:0]                         m_gait_phase,
    input  logic [1:0]                         m_odo_status,
    input  logic                               m_primary_switched,
    input  logic                               m_bad_transition,
    input  logic                               m_started,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [bgpc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [bgpc_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output int                                 failures,
    output int                                 outstanding,
    output int                                 results_checked,
    output int                                 switches_seen,
    output int                                 bad_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import bgpc_pkg::*;

    typedef struct packed {
        phase_t      phase;
        odo_status_t status;
        logic        switched;
        logic        bad;
        logic        started;
    } gait_result_t;

    // shadow of the gait state and the spans
    phase_t                   gait_phase;
    logic                     has_started;
    logic [TIME_BITS-1:0]     strike_at;
    logic [TIME_BITS-1:0]     break_at;
    logic [CFG_DATA_BITS-1:0] strike_span;
    logic [CFG_DATA_BITS-1:0] break_span;
    gait_result_t             expected_q [$];

    // a window is active while time is behind its mark or still inside the span
    function automatic logic in_window(input logic [TIME_BITS-1:0] now,
                                       input logic [TIME_BITS-1:0] since,
                                       input logic [CFG_DATA_BITS-1:0] span);
        logic [TIME_BITS-1:0] elapsed;
        elapsed = now - since;
        return (now < since) || (elapsed < TIME_BITS'(span));
    endfunction

    // one sample through the gait machine, then the odometry windows
    function automatic gait_result_t step_gait(input logic [TIME_BITS-1:0] now,
                                               input contact_t c);
        gait_result_t r;
        logic lw, rw, ls, rs;
        lw = c.left_weak;
        rw = c.right_weak;
        ls = c.left_strong;
        rs = c.right_strong;
        r = '0;
        if (!has_started) begin
            if (lw && rw) begin
                gait_phase = PH_L_STAND;
                has_started = 1'b1;
            end
        end else begin
            case (gait_phase)
                PH_L_STAND: begin
                    if (lw && !rs) begin
                        gait_phase = PH_L_BREAK;
                        break_at = now;
                    end else if (!ls && rw) begin
                        gait_phase = PH_R_BREAK;
                        break_at = now;
                        r.switched = 1'b1;
                    end else if (!(lw && rw)) begin
                        r.bad = 1'b1;
                    end
                end
                PH_L_BREAK: begin
                    if (lw && !rw) gait_phase = PH_L_SWING;
                    else if (lw && rs) gait_phase = PH_L_STAND;
                    else if (!(lw && !rs)) r.bad = 1'b1;
                end
                PH_L_SWING, PH_R_SWING: begin
                    // both feet down ends the swing; a lone opposite foot is unexpected
                    if (lw && rw) begin
                        gait_phase = (gait_phase == PH_L_SWING) ? PH_L_STRIKE : PH_R_STRIKE;
                        strike_at = now;
                    end else if ((gait_phase == PH_L_SWING) ? (!lw && rw) : (lw && !rw)) begin
                        r.bad = 1'b1;
                    end
                end
                PH_L_STRIKE: begin
                    if (lw && rs) gait_phase = PH_L_STAND;
                    else if (!(lw && !rs)) r.bad = 1'b1;
                end
                PH_R_STAND: begin
                    if (!ls && rw) begin
                        gait_phase = PH_R_BREAK;
                        break_at = now;
                    end else if (lw && !rs) begin
                        gait_phase = PH_L_BREAK;
                        break_at = now;
                        r.switched = 1'b1;
                    end else if (!(lw && rw)) begin
                        r.bad = 1'b1;
                    end
                end
                PH_R_BREAK: begin
                    if (!lw && rw) gait_phase = PH_R_SWING;
                    else if (ls && rw) gait_phase = PH_R_STAND;
                    else if (!(!ls && rw)) r.bad = 1'b1;
                end
                PH_R_STRIKE: begin
                    if (ls && rw) gait_phase = PH_R_STAND;
                    else if (!(!ls && rw)) r.bad = 1'b1;
                end
                default: r.bad = 1'b1;
            endcase
        end

        if (in_window(now, strike_at, strike_span)) r.status = ODO_UNUSABLE;
        else if (in_window(now, break_at, break_span)) r.status = ODO_INACCURATE;
        else r.status = ODO_ACCURATE;
        r.phase = gait_phase;
        r.started = has_started;
        return r;
    endfunction

    task automatic compare_field(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            failures++;
        end
    endtask

    // channel monitor: config first, then the result beat, then the new sample
    always @(posedge aclk) begin
        gait_result_t want;
        contact_t     seen;
        if (!aresetn) begin
            gait_phase = PH_UNKNOWN;
            has_started = 1'b0;
            strike_at = '0;
            break_at = '0;
            strike_span = STRIKE_BLACKOUT_RST;
            break_span = BREAK_BLACKOUT_RST;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_STRIKE_BLACKOUT) strike_span = cfg_data;
                else if (cfg_index == CFG_BREAK_BLACKOUT) break_span = cfg_data;
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, phase %0d status %0d",
                             $time, m_gait_phase, m_odo_status);
                    failures++;
                end else begin
                    want = expected_q.pop_front();
                    compare_field("gait_phase", want.phase, m_gait_phase);
                    compare_field("odo_status", want.status, m_odo_status);
                    compare_field("primary_switched", want.switched, m_primary_switched);
                    compare_field("bad_transition", want.bad, m_bad_transition);
                    compare_field("started", want.started, m_started);
                    results_checked++;
                    if (want.switched) switches_seen++;
                    if (want.bad) bad_seen++;
                end
            end
            if (s_valid && s_ready) begin
                seen = {s_left_weak, s_right_weak, s_left_strong, s_right_strong};
                expected_q.push_back(step_gait(s_time_us, seen));
            end
        end
        outstanding <= expected_q.size();
    end

endmodule

@@ tb/biped_gait_phase_classifier_tb.sv @@
// ----------------------------------------------------------------------------
// biped_gait_phase_classifier_tb
// Drives the gait phase classifier with a directed run through every phase
// and special case, then random walking sequences mixed with contact noise
// and timestamp jumps, over several blackout span settings. Both sides idle
// at random; the receiver holds off once for a long stretch. A checker
// module beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module biped_gait_phase_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bgpc_pkg::*;

    localparam int TB_TIME_BITS    = TIME_BITS_DEF;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int WALK_PER_SPAN   = 205;
    localparam int SPAN_SETTINGS   = 6;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int HOLD_OFF_AFTER  = 300;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 8'hFF;

    // one gait cycle per side: break, swing, strike, back to stand
    localparam contact_t LEFT_CYCLE  [4] = '{4'b1110, 4'b1010, 4'b1110, 4'b1111};
    localparam contact_t RIGHT_CYCLE [4] = '{4'b1101, 4'b0101, 4'b1101, 4'b1111};

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [TB_TIME_BITS-1:0]  s_time_us;
    logic                     s_left_weak;
    logic                     s_right_weak;
    logic                     s_left_strong;
    logic                     s_right_strong;
    logic                     m_valid;
    logic                     m_ready;
    logic [3:0]               m_gait_phase;
    logic [1:0]               m_odo_status;
    logic                     m_primary_switched;
    logic                     m_bad_transition;
    logic                     m_started;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    int                      failures;
    int                      outstanding;
    int                      results_checked;
    int                      switches_seen;
    int                      bad_seen;
    int                      samples_sent;
    int                      cycles;
    bit                      steady_send;
    bit                      held_off;
    logic [TB_TIME_BITS-1:0] clock_us;

    biped_gait_phase_classifier #(.TIME_BITS(TB_TIME_BITS)) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_time_us         (s_time_us),
        .s_left_weak       (s_left_weak),
        .s_right_weak      (s_right_weak),
        .s_left_strong     (s_left_strong),
        .s_right_strong    (s_right_strong),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_gait_phase      (m_gait_phase),
        .m_odo_status      (m_odo_status),
        .m_primary_switched(m_primary_switched),
        .m_bad_transition  (m_bad_transition),
        .m_started         (m_started),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    bgpc_checker #(.TIME_BITS(TB_TIME_BITS)) u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_time_us         (s_time_us),
        .s_left_weak       (s_left_weak),
        .s_right_weak      (s_right_weak),
        .s_left_strong     (s_left_strong),
        .s_right_strong    (s_right_strong),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_gait_phase      (m_gait_phase),
        .m_odo_status      (m_odo_status),
        .m_primary_switched(m_primary_switched),
        .m_bad_transition  (m_bad_transition),
        .m_started         (m_started),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .failures          (failures),
        .outstanding       (outstanding),
        .results_checked   (results_checked),
        .switches_seen     (switches_seen),
        .bad_seen          (bad_seen)
    );

    // 4 ns clock
    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycles, outstanding);
            $display("== FAIL ==");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // next timestamp: small steps, window-sized steps, wild jumps, going back
    function automatic logic [TB_TIME_BITS-1:0] next_time(input logic [TB_TIME_BITS-1:0] now);
        logic [63:0] wide;
        int          r;
        r = $urandom_range(0, 99);
        wide = {$urandom, $urandom};
        if (r < 40) return now + TB_TIME_BITS'($urandom_range(0, 3000));
        if (r < 75) return now + TB_TIME_BITS'($urandom_range(0, 150000));
        if (r < 93) return now + TB_TIME_BITS'($urandom_range(0, 1200000));
        if (r < 97) return wide[TB_TIME_BITS-1:0];
        return now - TB_TIME_BITS'($urandom_range(0, 100000));
    endfunction

    // one sample beat, then an optional gap
    task automatic send_sample(input logic [TB_TIME_BITS-1:0] t, input contact_t c);
        int gap;
        s_valid        <= 1'b1;
        s_time_us      <= t;
        s_left_weak    <= c.left_weak;
        s_right_weak   <= c.right_weak;
        s_left_strong  <= c.left_strong;
        s_right_strong <= c.right_strong;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
        clock_us = t;
        gap = steady_send ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // span writes, valid held across beats; the stray index must be ignored
    task automatic write_spans(input logic [CFG_DATA_BITS-1:0] strike,
                               input logic [CFG_DATA_BITS-1:0] brk, input bit stray);
        if (stray) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_UNUSED_IDX;
            cfg_data  <= CFG_DATA_BITS'($urandom);
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b1;
        cfg_index <= CFG_STRIKE_BLACKOUT;
        cfg_data  <= strike;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_BREAK_BLACKOUT;
        cfg_data  <= brk;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // stop sending and wait until every sample in flight has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (4) @(posedge aclk);
    endtask

    // walking cycles with repeats, cut short now and then, mixed with noise
    task automatic random_walk(input int count);
        int          done_here;
        int          k;
        int          rep;
        bit          right_side;
        logic [3:0]  noise;
        contact_t    pat;
        done_here = 0;
        while (done_here < count) begin
            if ($urandom_range(0, 99) < 12) begin
                noise = 4'($urandom_range(0, 15));
                pat = noise;
                send_sample(next_time(clock_us), pat);
                done_here++;
            end else begin
                right_side = 1'($urandom_range(0, 1));
                for (k = 0; k < 4; k++) begin
                    if ($urandom_range(0, 19) == 0) break;
                    pat = right_side ? RIGHT_CYCLE[k] : LEFT_CYCLE[k];
                    rep = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(1, 2);
                    repeat (rep) begin
                        send_sample(next_time(clock_us), pat);
                        done_here++;
                    end
                end
            end
        end
    endtask

    // receiver: random ready pattern, one long hold-off part way through
    initial begin
        int on_len;
        int gap;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!held_off && results_checked >= HOLD_OFF_AFTER) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                held_off = 1'b1;
            end else begin
                on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 6);
                m_ready <= 1'b1;
                repeat (on_len) @(posedge aclk);
                gap = pick_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // stimulus and verdict
    initial begin
        int setting;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_time_us      <= '0;
        s_left_weak    <= 1'b0;
        s_right_weak   <= 1'b0;
        s_left_strong  <= 1'b0;
        s_right_strong <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        clock_us = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // not started yet: windows run against the zero marks
        send_sample(48'd0,       4'b0000);
        send_sample(48'd100000,  4'b1000);
        send_sample(48'd900000,  4'b0100);
        send_sample(48'd900000,  4'b0011);
        // both weak contacts: start in left stand
        send_sample(48'd1000000, 4'b1100);
        send_sample(48'd1010000, 4'b0000);
        send_sample(48'd1020000, 4'b1110);
        send_sample(48'd1030000, 4'b1111);
        // switch to right break, then a full right cycle
        send_sample(48'd1040000, 4'b1101);
        send_sample(48'd1050000, 4'b0000);
        send_sample(48'd1060000, 4'b1111);
        send_sample(48'd1070000, 4'b1101);
        send_sample(48'd1080000, 4'b0101);
        send_sample(48'd1090000, 4'b0000);
        send_sample(48'd1100000, 4'b1000);
        send_sample(48'd1110000, 4'b1101);
        send_sample(48'd1120000, 4'b1000);
        send_sample(48'd1130000, 4'b1111);
        // switch back to left, strike at the top of the time range
        send_sample(48'd1140000, 4'b1110);
        send_sample(48'd1150000, 4'b1010);
        send_sample(48'd1160000, 4'b0100);
        send_sample(48'hFFFF_FFFF_FFFF, 4'b1111);
        // time steps backwards behind the strike mark
        send_sample(48'd5,       4'b0000);
        send_sample(48'd10,      4'b1111);

        for (setting = 0; setting < SPAN_SETTINGS; setting++) begin
            if (setting > 0) drain();
            case (setting)
                1: write_spans(24'd0, 24'd0, 1'b1);
                2: write_spans(24'hFF_FFFF, 24'hFF_FFFF, 1'b0);
                3: write_spans(CFG_DATA_BITS'($urandom_range(0, 200000)),
                               CFG_DATA_BITS'($urandom_range(0, 2000000)), 1'b0);
                4: write_spans(24'd800000, 24'd95000, 1'b1);
                5: write_spans(STRIKE_BLACKOUT_RST, BREAK_BLACKOUT_RST, 1'b0);
                default: ;
            endcase
            steady_send = (setting == 2);
            random_walk(WALK_PER_SPAN);
        end
        s_valid <= 1'b0;

        drain();
        repeat (8) @(posedge aclk);
        $display("%0d samples over %0d span settings, %0d results checked",
                 samples_sent, SPAN_SETTINGS, results_checked);
        $display("%0d primary switches, %0d unmatched patterns, receiver hold-off %s",
                 switches_seen, bad_seen, held_off ? "done" : "not reached");
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", failures);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
